// ===== hw/rtl/stream_pattern_masker_top_defines.svh =====
// Assertion macros shared by the pattern masker RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef STREAM_PATTERN_MASKER_TOP_DEFINES_SVH
`define STREAM_PATTERN_MASKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spm check failed");

`endif

// ===== hw/rtl/spm_pkg.sv =====
// Shared constants and types for the stream pattern masker.
// Used by every module of the block; depends on nothing.
package spm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

    // Control shared by all cells of the window chain.
    typedef struct packed {
        logic accept;   // a new byte enters the cell selected by the fill count
        logic shift;    // every cell takes the work byte of its right neighbor
    } cell_ctrl_t;

    // One emission handed from the scan control to the output stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;      // last flag for the first byte shown
        logic [LEN_W-1:0]  extra;     // further stars that follow this byte
        logic              run_last;  // the final star of the run closes the stream
    } emit_t;

endpackage

// ===== hw/rtl/spm_cell.sv =====
// One cell of the pending window: holds a byte, compares it with its pattern byte.
// Depends on spm_pkg.
module spm_cell (
    input  logic                       clk,
    input  spm_pkg::cell_ctrl_t        ctrl,
    input  logic                       sel_new,
    input  logic [spm_pkg::BYTE_W-1:0] in_byte,
    input  logic [spm_pkg::BYTE_W-1:0] right_work,
    input  logic [spm_pkg::BYTE_W-1:0] pat_byte,
    output logic [spm_pkg::BYTE_W-1:0] work_byte,
    output logic                       match
);

    logic [spm_pkg::BYTE_W-1:0] byte_reg;
    logic [spm_pkg::BYTE_W-1:0] byte_next;

    // The arriving byte shows up in the cell right behind the pending bytes.
    assign work_byte = (ctrl.accept && sel_new) ? in_byte : byte_reg;
    assign match     = (work_byte == pat_byte);

    always_comb
    begin
        if (ctrl.shift)
        begin
            byte_next = right_work;
        end
        else if (ctrl.accept)
        begin
            byte_next = work_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ===== hw/rtl/spm_out_stage.sv =====
// Output register of the masker with a star run counter.
// Depends on spm_pkg and the assertion macro header.
`include "stream_pattern_masker_top_defines.svh"

module spm_out_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spm_pkg::emit_t             emit,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [spm_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       free
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [spm_pkg::BYTE_W-1:0] byte_reg;
    logic [spm_pkg::BYTE_W-1:0] byte_next;
    logic                       last_reg;
    logic                       last_next;
    logic [spm_pkg::LEN_W-1:0]  star_left_reg;
    logic [spm_pkg::LEN_W-1:0]  star_left_next;
    logic                       star_last_reg;
    logic                       star_last_next;
    logic                       take;

    assign take = valid_reg && !out_stall;
    assign free = !valid_reg || (take && (star_left_reg == '0));

    always_comb
    begin
        valid_next     = valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        star_left_next = star_left_reg;
        star_last_next = star_last_reg;
        if (emit.valid && free)
        begin
            valid_next     = 1'b1;
            byte_next      = emit.data;
            last_next      = emit.last;
            star_left_next = emit.extra;
            star_last_next = emit.run_last;
        end
        else if (take)
        begin
            if (star_left_reg != '0)
            begin
                star_left_next = star_left_reg - spm_pkg::LEN_W'(1);
                last_next      = star_last_reg &&
                                 (star_left_reg == spm_pkg::LEN_W'(1));
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            star_left_reg <= '0;
            star_last_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            star_left_reg <= star_left_next;
            star_last_reg <= star_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    `SPM_ASSERT_NOW(a_run_is_stars, clk, rst_n, star_left_reg != '0,
                    valid_reg && (byte_reg == spm_pkg::STAR_BYTE))
    `SPM_ASSERT_NOW(a_last_ends_run, clk, rst_n, valid_reg && last_reg,
                    star_left_reg == '0)

endmodule

// ===== hw/rtl/stream_pattern_masker_top.sv =====
// Top level of the stream pattern masker: config registers, scan control, cell chain.
// Depends on spm_pkg, spm_cell, spm_out_stage and the assertion macro header.
//
// Usage: bytes of a text stream enter on in_valid/in_stall with in_byte and in_last.
// Every leftmost, non-overlapping occurrence of the configured pattern is replaced
// by as many '*' bytes; all other bytes leave unchanged and in order on
// out_valid/out_stall with out_byte and out_last. An item is taken at a clock edge
// where valid is high and stall is low. The pattern and its length are written on
// the cfg channel (index 0 low pattern bytes, 1 high pattern bytes, 2 length) while
// the stream is idle; a length of zero passes bytes straight through.
// A byte that completes a match or pushes the oldest pending byte out produces its
// first output item in the cycle after it is accepted. Throughput is one item per
// cycle in steady state while out_stall is low, set by the single output register:
// a match releases its stars one per cycle while the window refills behind them.
// A byte marked last keeps the step running until all pending bytes are flushed,
// and a shortened length keeps it running while bytes are rescanned or dropped.
// Reset clears control and config state, empties the window and drops held output; the
// window needs no clearing pass. When the receiver stalls, the output item holds,
// and input stalls as soon as an arriving byte would need the output register.
`include "stream_pattern_masker_top_defines.svh"

module stream_pattern_masker_top #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [spm_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [spm_pkg::BYTE_W-1:0]     out_byte,
    output logic                           out_last
);

    // Counts range from zero up to the full window.
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers.
    logic [spm_pkg::CFG_DATA_W-1:0] pat_lo_reg;
    logic [spm_pkg::CFG_DATA_W-1:0] pat_hi_reg;
    logic [spm_pkg::LEN_W-1:0]      pat_len_reg;
    logic [2*spm_pkg::CFG_DATA_W-1:0] pat_all;

    // Scan control state.
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] drop_reg;
    logic [CNT_W-1:0] drop_next;
    logic             busy_reg;
    logic             busy_next;
    logic             flush_reg;
    logic             flush_next;

    logic [CNT_W-1:0] len;
    logic             len_zero;
    logic             accept;
    logic             need_out;
    logic             out_free;
    logic             last_now;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] rem_after;
    logic [CNT_W-1:0] rem_pop;
    logic             drop_phase;
    logic             iter;
    logic             cond_loop;
    logic             want_emit;
    logic             emit_go;
    logic             hit;
    logic             more;
    logic             more_drop;
    logic             run_end;

    logic [MAX_PATTERN-1:0]         match_vec;
    logic [MAX_PATTERN-1:0]         len_mask;
    logic [spm_pkg::BYTE_W-1:0]     work_bytes [MAX_PATTERN];
    spm_pkg::cell_ctrl_t            cell_ctrl;
    spm_pkg::emit_t                 emit;

    // The step goes on while enough bytes remain for a pattern compare, or
    // while a flush still has bytes to release.
    function automatic logic more_f(input logic [CNT_W-1:0] r,
                                    input logic [CNT_W-1:0] l,
                                    input logic             fl);
        more_f = (r != '0) && ((l == '0) || (r >= l) || fl);
    endfunction

    //------------------------------------------------------------------
    // Configuration port, always ready. The user must let writes land only while
    // the stream is idle; the block does not enforce it. Unknown indexes are ignored.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spm_pkg::CFG_PAT_LO:  pat_lo_reg  <= cfg_data;
                spm_pkg::CFG_PAT_HI:  pat_hi_reg  <= cfg_data;
                spm_pkg::CFG_PAT_LEN: pat_len_reg <= cfg_data[spm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all = {pat_hi_reg, pat_lo_reg};

    // Lengths beyond the window behave as a full-window pattern.
    assign len = (pat_len_reg > spm_pkg::LEN_W'(MAX_PATTERN)) ?
                 CNT_W'(MAX_PATTERN) : CNT_W'(pat_len_reg);
    assign len_zero = (len == '0);

    //------------------------------------------------------------------
    // Input handshake. A new byte is refused while a scan step is
    // running, or when it would emit and the output register is occupied.
    //------------------------------------------------------------------
    assign need_out = ((cnt_reg + CNT_W'(1)) >= len) || in_last;
    assign in_stall = busy_reg || (need_out && !out_free);
    assign accept   = in_valid && !in_stall;

    //------------------------------------------------------------------
    // Scan step. The head of the work window is always cell 0: a released
    // byte or a matched byte leaves by shifting the chain one cell.
    //------------------------------------------------------------------
    assign rem        = accept ? (cnt_reg + CNT_W'(1)) : cnt_reg;
    assign last_now   = accept ? in_last : flush_reg;
    assign drop_phase = busy_reg && (drop_reg != '0);
    assign iter       = (accept || busy_reg) && !drop_phase;
    assign cond_loop  = (rem != '0) && (len_zero || (rem >= len));
    assign want_emit  = iter && (cond_loop || (last_now && (rem != '0)));
    assign emit_go    = want_emit && out_free;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            len_mask[k] = (CNT_W'(k) < len);
        end
    end

    assign hit       = !len_zero && (rem >= len) && (&(match_vec | ~len_mask));
    assign rem_after = hit ? (rem - len) : (rem - CNT_W'(1));
    assign rem_pop   = rem - CNT_W'(1);
    assign more      = more_f(rem_after, len, last_now);
    assign more_drop = more_f(rem_pop, len, flush_reg);
    assign run_end   = last_now && (rem_after == '0);

    assign cell_ctrl.accept = accept;
    assign cell_ctrl.shift  = emit_go || drop_phase;

    always_comb
    begin
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        busy_next  = busy_reg;
        flush_next = flush_reg;
        if (drop_phase)
        begin
            // Bytes behind the first of a match leave the window silently.
            cnt_next  = rem_pop;
            drop_next = drop_reg - CNT_W'(1);
            busy_next = (drop_reg == CNT_W'(1)) ? more_drop : 1'b1;
        end
        else if (emit_go)
        begin
            flush_next = last_now;
            if (hit && (rem_after == '0))
            begin
                cnt_next  = '0;
                drop_next = '0;
                busy_next = 1'b0;
            end
            else if (hit)
            begin
                cnt_next  = rem_pop;
                drop_next = len - CNT_W'(1);
                busy_next = (len != CNT_W'(1)) || more;
            end
            else
            begin
                cnt_next  = rem_pop;
                drop_next = '0;
                busy_next = more;
            end
        end
        else if (accept)
        begin
            // The byte only joins the pending window.
            cnt_next   = rem;
            busy_next  = 1'b0;
            flush_next = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            drop_reg  <= '0;
            busy_reg  <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            busy_reg  <= busy_next;
            flush_reg <= flush_next;
        end
    end

    //------------------------------------------------------------------
    // Window chain: cell k holds pending byte k and compares it with
    // pattern byte k every cycle.
    //------------------------------------------------------------------
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [spm_pkg::BYTE_W-1:0] right_work;

        if (k == MAX_PATTERN - 1)
        begin : g_tail
            assign right_work = '0;
        end
        else
        begin : g_link
            assign right_work = work_bytes[k+1];
        end

        spm_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .sel_new    (cnt_reg == CNT_W'(k)),
            .in_byte    (in_byte),
            .right_work (right_work),
            .pat_byte   (pat_all[spm_pkg::BYTE_W*k +: spm_pkg::BYTE_W]),
            .work_byte  (work_bytes[k]),
            .match      (match_vec[k])
        );
    end

    //------------------------------------------------------------------
    // Output stage. A match hands over one star plus a count of further
    // stars; a miss or a flush hands over the head byte.
    //------------------------------------------------------------------
    assign emit.valid    = emit_go;
    assign emit.data     = hit ? spm_pkg::STAR_BYTE : work_bytes[0];
    assign emit.last     = run_end && (!hit || (len == CNT_W'(1)));
    assign emit.extra    = hit ? spm_pkg::LEN_W'(len - CNT_W'(1)) : '0;
    assign emit.run_last = run_end;

    spm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .free      (out_free)
    );

    `SPM_ASSERT_NOW(a_window_bound, clk, rst_n, 1'b1,
                    cnt_reg <= CNT_W'(MAX_PATTERN - 1))
    `SPM_ASSERT_NOW(a_drop_in_step, clk, rst_n, drop_reg != '0, busy_reg)
    `SPM_ASSERT_NEXT(a_flush_empties, clk, rst_n, accept && in_last,
                     busy_reg || (cnt_reg == '0))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stream_pattern_masker_top: directed and random byte streams
// against an independent masking predictor. Depends on spm_pkg and the block's RTL.

module tb_top;
    import spm_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 300;
    // Quiet cycles after the last expected item: covers a flush of a full window
    // plus a rescan after a length change, with room to spare.
    localparam int SETTLE_CYCLES  = 48;
    // Cycles with no handshake of any kind before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;

    // One output item as the predictor expects it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } masked_item_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     in_byte   = '0;
    logic                  in_last   = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  out_last;

    stream_pattern_masker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state. The shadow registers follow every configuration
    // write seen on the bus; the held bytes mirror the block's window of
    // bytes that might still begin a match.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] shadow_pat_lo  = '0;
    logic [CFG_DATA_W-1:0] shadow_pat_hi  = '0;
    logic [LEN_W-1:0]      shadow_len     = '0;
    logic [BYTE_W-1:0]     held_bytes [0:MAX_PATTERN-2];
    int unsigned           held_count     = 0;
    masked_item_t          masked_q [$];

    masked_item_t          arrived_want;
    bit                    progress;
    int                    idle_cycles    = 0;
    int                    fails          = 0;
    int                    sent_items     = 0;

    // Stimulus-side view of the pattern, used to build streams that match.
    logic [BYTE_W-1:0]     stim_pat [0:MAX_PATTERN-1];
    int unsigned           stim_len       = 0;

    // Sender burst control and receiver stall pattern.
    int                    burst_left     = 0;
    bit                    sender_eager   = 1'b0;
    int                    stall_style    = 0;
    int                    stall_left     = 0;
    int unsigned           tick           = 0;

    function automatic logic [BYTE_W-1:0] pattern_at(int unsigned k);
        if (k < 8)
            return shadow_pat_lo[8*k +: 8];
        return shadow_pat_hi[8*(k-8) +: 8];
    endfunction

    // Works out the output items caused by one accepted byte. The window plus
    // the new byte is scanned from the oldest byte: a full match releases a run
    // of stars, otherwise the oldest byte leaves as it is. Scanning stops once
    // fewer bytes remain than the pattern is long. A byte marked last flushes
    // the rest and tags the final item of this step.
    function automatic void predict_masking(logic [BYTE_W-1:0] b, logic l);
        logic [BYTE_W-1:0] work [0:MAX_PATTERN-1];
        masked_item_t      batch [0:MAX_PATTERN-1];
        int unsigned       n;
        int unsigned       len;
        int unsigned       head;
        int unsigned       count;
        int unsigned       k;
        bit                hit;
        len   = (shadow_len > MAX_PATTERN) ? MAX_PATTERN : 32'(shadow_len);
        n     = held_count;
        head  = 0;
        count = 0;
        for (k = 0; k < n; k++)
            work[k] = held_bytes[k];
        work[n] = b;
        n++;
        while (n > head && (len == 0 || n - head >= len))
        begin
            hit = (len != 0);
            for (k = 0; k < len; k++)
                if (work[head+k] != pattern_at(k))
                    hit = 1'b0;
            if (hit)
            begin
                for (k = 0; k < len; k++)
                begin
                    batch[count].data = STAR_BYTE;
                    batch[count].last = 1'b0;
                    count++;
                end
                head += len;
            end
            else
            begin
                batch[count].data = work[head];
                batch[count].last = 1'b0;
                count++;
                head++;
            end
        end
        if (l)
        begin
            while (head < n)
            begin
                batch[count].data = work[head];
                batch[count].last = 1'b0;
                count++;
                head++;
            end
            if (count > 0)
                batch[count-1].last = 1'b1;
        end
        held_count = n - head;
        for (k = 0; k < held_count; k++)
            held_bytes[k] = work[head+k];
        for (k = 0; k < count; k++)
            masked_q.push_back(batch[k]);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Configuration
    // writes update the shadow registers, accepted input items feed the
    // predictor, and accepted output items are checked against the oldest
    // expectation. Any handshake clears the watchdog count.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                progress = 1'b1;
                case (cfg_index)
                    CFG_PAT_LO:  shadow_pat_lo = cfg_data;
                    CFG_PAT_HI:  shadow_pat_hi = cfg_data;
                    CFG_PAT_LEN: shadow_len    = cfg_data[LEN_W-1:0];
                    default:     ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                progress = 1'b1;
                predict_masking(in_byte, in_last);
            end
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                if (masked_q.size() == 0)
                begin
                    $error("out_byte: expected no item, actual %02h", out_byte);
                    fails++;
                end
                else
                begin
                    arrived_want = masked_q.pop_front();
                    if (out_byte !== arrived_want.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h",
                               arrived_want.data, out_byte);
                        fails++;
                    end
                    if (out_last !== arrived_want.last)
                    begin
                        $error("out_last: expected %0b, actual %0b",
                               arrived_want.last, out_last);
                        fails++;
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
        end
    end

    // The watchdog ends a run in which nothing moves for too long.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver stalls follow a style that is redrawn at random times: never, light
    // random, heavy random, or a fixed periodic pattern.
    always @(negedge clk)
    begin
        tick <= tick + 1;
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(20, 120);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ((tick % 5) >= 2);
        endcase
    end

    // ------------------------------------------------------------------
    // Shared drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Sends one byte. Items go out in bursts; before each burst the valid
    // line drops for a random gap unless the sender is in its eager mode.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = sender_eager ? 0 : $urandom_range(0, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        in_byte  = b;
        in_last  = l;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
            in_valid = 1'b0;
        sent_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every expected item has come out, then lets the block
    // finish any internal work that produces nothing visible.
    task automatic settle();
        in_valid = 1'b0;
        while (masked_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three registers from the stimulus copy of the pattern.
    task automatic load_pattern(input logic [CFG_DATA_W-1:0] len_value);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        int                    k;
        for (k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = stim_pat[k];
            hi[8*k +: 8] = stim_pat[k+8];
        end
        write_reg(CFG_PAT_LO, lo);
        write_reg(CFG_PAT_HI, hi);
        write_reg(CFG_PAT_LEN, len_value);
        stim_len = (len_value[LEN_W-1:0] > MAX_PATTERN) ? MAX_PATTERN
                                                         : 32'(len_value[LEN_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Out of reset the length is zero, so bytes pass straight through.
    task automatic test_pass_through();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // A three-byte pattern of NUL, all-ones and the star byte itself: a clean
    // match, a false start that still ends in a match, and a flush that
    // releases a pending partial match.
    task automatic test_nul_and_extremes();
        int k;
        settle();
        for (k = 0; k < MAX_PATTERN; k++)
            stim_pat[k] = 8'($urandom);
        stim_pat[0] = 8'h00;
        stim_pat[1] = 8'hFF;
        stim_pat[2] = STAR_BYTE;
        load_pattern(64'd3);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(STAR_BYTE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(STAR_BYTE, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Pattern "aa" over a run of five: matches must not overlap, so the odd
    // byte out is released by the flush. The length is written with its
    // upper data bits set; only the low five bits count.
    task automatic test_no_overlap();
        settle();
        stim_pat[0] = 8'h61;
        stim_pat[1] = 8'h61;
        load_pattern(64'hFFFF_FFFF_FFFF_FFE2);
        repeat (4) send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b1);
    endtask

    // Three bytes wait in the window under length four; the length then
    // shrinks to two, and the next byte rescans the window with it.
    task automatic test_length_change();
        settle();
        stim_pat[0] = 8'h01;
        stim_pat[1] = 8'h02;
        stim_pat[2] = 8'h03;
        stim_pat[3] = 8'h04;
        load_pattern(64'd4);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h03, 1'b0);
        settle();
        write_reg(CFG_PAT_LEN, 64'd2);
        stim_len = 2;
        send_item(8'h7F, 1'b1);
    endtask

    // A length beyond the maximum is clamped; a lone last byte on an empty
    // window still yields exactly one tagged item.
    task automatic test_overlong_length();
        settle();
        load_pattern(64'd31);
        send_item(stim_pat[0] ^ 8'h01, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random streams. Each phase picks a configuration, mostly a new pattern
    // drawn from a small alphabet so that matches are common, sometimes only
    // a new length over the old pattern while bytes are still pending. The
    // stream is mostly whole occurrences, with broken prefixes, noise bytes
    // and stream ends mixed in.
    // ------------------------------------------------------------------
    task automatic test_random_streams();
        logic [BYTE_W-1:0]     alpha [0:3];
        logic [CFG_DATA_W-1:0] len_value;
        int                    phase;
        int                    target;
        int                    budget;
        int                    kind;
        int                    cut;
        int                    k;
        phase  = 0;
        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target)
        begin
            settle();
            sender_eager = ($urandom_range(0, 3) == 0);
            case (phase)
                0:       len_value = 64'd16;
                1:       len_value = 64'd31;
                2:       len_value = 64'd0;
                3:       len_value = 64'd1;
                default: len_value = ($urandom_range(0, 4) == 0) ?
                                     64'($urandom_range(0, 31)) :
                                     64'($urandom_range(1, 6));
            endcase
            if (phase % 4 == 3)
            begin
                write_reg(CFG_PAT_LEN, len_value);
                stim_len = (len_value[LEN_W-1:0] > MAX_PATTERN) ? MAX_PATTERN
                                                                 : 32'(len_value[LEN_W-1:0]);
            end
            else
            begin
                for (k = 0; k < 4; k++)
                    alpha[k] = 8'($urandom);
                for (k = 0; k < MAX_PATTERN; k++)
                    stim_pat[k] = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                              : alpha[$urandom_range(0, 3)];
                load_pattern(len_value);
            end
            budget = sent_items + $urandom_range(15, 40);
            while (sent_items < budget)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 4)
                begin
                    for (k = 0; k < stim_len; k++)
                        send_item(stim_pat[k], 1'b0);
                    if (stim_len == 0)
                        send_item(8'($urandom), 1'b0);
                end
                else if (kind <= 6)
                begin
                    cut = (stim_len > 1) ? $urandom_range(1, stim_len - 1) : 0;
                    for (k = 0; k < cut; k++)
                        send_item(stim_pat[k], 1'b0);
                    send_item(stim_pat[$urandom_range(0, MAX_PATTERN - 1)], 1'b0);
                end
                else if (kind == 7)
                begin
                    send_item(8'($urandom), 1'b0);
                end
                else if (kind == 8)
                begin
                    send_item(stim_pat[$urandom_range(0, MAX_PATTERN - 1)], 1'b0);
                end
                else
                begin
                    send_item($urandom_range(0, 1) ? stim_pat[0] : 8'($urandom), 1'b1);
                end
            end
            // Half the phases close their stream; the rest leave bytes pending
            // across the next configuration change.
            if ($urandom_range(0, 1))
                send_item(8'($urandom), 1'b1);
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_pass_through();
        test_nul_and_extremes();
        test_no_overlap();
        test_length_change();
        test_overlong_length();
        test_random_streams();
        settle();
        if (fails == 0 && masked_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/spm_pkg.sv
hw/rtl/spm_cell.sv
hw/rtl/spm_out_stage.sv
hw/rtl/stream_pattern_masker_top.sv
tb/tb_top.sv
